// ----- hdl/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bfiq_pkg.sv -----
package bfiq_pkg;

  // request kinds
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SEED   = 2'd0;
  localparam logic [1:0] CFG_COUNT  = 2'd1;
  localparam logic [1:0] CFG_BITS   = 2'd2;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // register reset values
  localparam logic [31:0] SEED_RST  = 32'd0;
  localparam logic [3:0]  COUNT_RST = 4'd5;
  localparam logic [12:0] BITS_RST  = 13'd4096;

  // jhash single-word final mix
  localparam logic [31:0] MIX_INIT   = 32'hDEADBEEF + 32'd4;
  localparam int          MIX_ROUNDS = 7;

  // remainder unit: bits of the hash retired per cycle
  localparam int MOD_RADIX_BITS = 4;
  localparam int MOD_STEPS      = 32 / MOD_RADIX_BITS;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SEED,
    ST_MIX,
    ST_MOD,
    ST_RD,
    ST_UPD,
    ST_FIN
  } st_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] k);
    logic [63:0] d;
    d = {x, x} << k;
    return d[63:32];
  endfunction

endpackage

// ----- hdl/bloom_filter_insert_query.sv -----
// bloom filter over 32-bit keys, one probe at a time against a 64-bit-wide word store
// insert/query: each probe is a seed step, 7 mix rounds, 8 remainder steps at 4 bits
//   each, a memory read and an update; a query ends early on a clear bit, and out_tvalid
//   rises via ST_FIN once any held result is taken; one request in flight at a time
// clear: one word written per cycle through the single write port until every word is zero
// reset (rst_n, synchronous, active low): control and cfg registers to defaults, then a
//   clearing pass over every word during which in_tready stays low; cfg writes are taken throughout
module bloom_filter_insert_query #(
  parameter int STORE_WORDS = 64,
  parameter int MAX_HASHES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] maybe_present, [7:1] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int STORE_BITS = STORE_WORDS * 64;
  localparam int SBW  = $clog2(STORE_BITS + 1);         // modulus width
  localparam int RW   = SBW + 1;                        // partial remainder width
  localparam int AW   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CW   = $clog2(MAX_HASHES + 1);         // probe counter width
  localparam int MIXW = $clog2(bfiq_pkg::MIX_ROUNDS);
  localparam int MODW = $clog2(bfiq_pkg::MOD_STEPS);
  localparam int RB   = bfiq_pkg::MOD_RADIX_BITS;

  // configuration registers
  logic [31:0] hash_seed_r;
  logic [3:0]  hash_count_r;
  logic [12:0] bit_count_r;

  // control and datapath
  bfiq_pkg::st_t state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r;
  logic [1:0]      req_r;
  logic [31:0]     key_r;
  logic [CW-1:0]   probe_r;
  logic [MIXW-1:0] mix_cnt_r;
  logic [MODW-1:0] mod_cnt_r;
  logic [31:0]     a_r, b_r, c_r;
  logic [31:0]     a_nxt, b_nxt, c_nxt;
  logic [31:0]     div_r;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic            hit_r;
  logic            out_valid_r;
  logic            out_bit_r;

  // store: one write port, one registered read port
  logic [63:0]   mem [STORE_WORDS];
  logic [63:0]   rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [63:0]   mem_wd;

  // derived configuration: clamped probe total and modulus
  logic [CW-1:0]  probe_total;
  logic [SBW-1:0] modulus;
  logic [5:0]     bit_pos;
  logic           probe_bit;
  logic           last_probe;
  logic           accept;
  logic [31:0]    seed_mix;

  always_comb begin
    priority if (hash_count_r == 4'd0) probe_total = CW'(1);
    else if (32'(hash_count_r) > 32'(MAX_HASHES)) probe_total = CW'(MAX_HASHES);
    else probe_total = CW'(hash_count_r);
  end

  always_comb begin
    if (bit_count_r == 13'd0 || 32'(bit_count_r) > 32'(STORE_BITS)) modulus = SBW'(STORE_BITS);
    else modulus = SBW'(bit_count_r);
  end

  assign accept     = in_tvalid && in_tready;
  assign last_probe = (probe_r == probe_total - CW'(1));
  assign rd_addr    = AW'(rem_r >> 6);
  assign bit_pos    = rem_r[5:0];
  assign probe_bit  = rd_data_r[bit_pos];
  assign seed_mix   = bfiq_pkg::MIX_INIT + hash_seed_r + 32'(probe_r);

  // configuration port: always ready, writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r  <= bfiq_pkg::SEED_RST;
      hash_count_r <= bfiq_pkg::COUNT_RST;
      bit_count_r  <= bfiq_pkg::BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfiq_pkg::CFG_SEED:  hash_seed_r  <= cfg_data;
        bfiq_pkg::CFG_COUNT: hash_count_r <= cfg_data[3:0];
        bfiq_pkg::CFG_BITS:  bit_count_r  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // one jhash mix round, selected by the round counter
  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    unique case (mix_cnt_r)
      MIXW'(0): c_nxt = (c_r ^ b_r) - bfiq_pkg::rotl32(b_r, 5'd14);
      MIXW'(1): a_nxt = (a_r ^ c_r) - bfiq_pkg::rotl32(c_r, 5'd11);
      MIXW'(2): b_nxt = (b_r ^ a_r) - bfiq_pkg::rotl32(a_r, 5'd25);
      MIXW'(3): c_nxt = (c_r ^ b_r) - bfiq_pkg::rotl32(b_r, 5'd16);
      MIXW'(4): a_nxt = (a_r ^ c_r) - bfiq_pkg::rotl32(c_r, 5'd4);
      MIXW'(5): b_nxt = (b_r ^ a_r) - bfiq_pkg::rotl32(a_r, 5'd14);
      default:  c_nxt = (c_r ^ b_r) - bfiq_pkg::rotl32(b_r, 5'd24);
    endcase
  end

  // restoring remainder, RB hash bits per cycle from the top down
  always_comb begin
    logic [RW-1:0] t;
    t = rem_r;
    for (int k = 0; k < RB; k++) begin
      t = {t[RW-2:0], div_r[31 - k]};
      if (t >= {1'b0, modulus}) t = t - {1'b0, modulus};
    end
    rem_nxt = t;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfiq_pkg::ST_CLR:
        if (clr_cnt_r == AW'(STORE_WORDS - 1)) state_nxt = bfiq_pkg::ST_IDLE;
      bfiq_pkg::ST_IDLE:
        if (accept) begin
          priority case (in_tuser)
            bfiq_pkg::REQ_INSERT, bfiq_pkg::REQ_QUERY: state_nxt = bfiq_pkg::ST_SEED;
            bfiq_pkg::REQ_CLEAR:                       state_nxt = bfiq_pkg::ST_CLR;
            default:                                   state_nxt = bfiq_pkg::ST_IDLE;
          endcase
        end
      bfiq_pkg::ST_SEED: state_nxt = bfiq_pkg::ST_MIX;
      bfiq_pkg::ST_MIX:
        if (mix_cnt_r == MIXW'(bfiq_pkg::MIX_ROUNDS - 1)) state_nxt = bfiq_pkg::ST_MOD;
      bfiq_pkg::ST_MOD:
        if (mod_cnt_r == MODW'(bfiq_pkg::MOD_STEPS - 1)) state_nxt = bfiq_pkg::ST_RD;
      bfiq_pkg::ST_RD: state_nxt = bfiq_pkg::ST_UPD;
      bfiq_pkg::ST_UPD:
        if (req_r == bfiq_pkg::REQ_QUERY) begin
          if (!probe_bit || last_probe) state_nxt = bfiq_pkg::ST_FIN;
          else state_nxt = bfiq_pkg::ST_SEED;
        end else begin
          if (last_probe) state_nxt = bfiq_pkg::ST_IDLE;
          else state_nxt = bfiq_pkg::ST_SEED;
        end
      bfiq_pkg::ST_FIN:
        if (!out_valid_r || out_tready) state_nxt = bfiq_pkg::ST_IDLE;
      default: state_nxt = bfiq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and store write port
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = rd_addr;
    mem_wd    = rd_data_r | (64'd1 << bit_pos);
    unique case (state_r)
      bfiq_pkg::ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_r;
        mem_wd = 64'd0;
      end
      bfiq_pkg::ST_IDLE: in_tready = 1'b1;
      bfiq_pkg::ST_UPD:  mem_we = (req_r == bfiq_pkg::REQ_INSERT);
      default: ;
    endcase
  end

  // store; the read of a probe always follows the previous probe's write-back,
  // so a word is never read while its update is still outstanding
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfiq_pkg::ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bfiq_pkg::ST_CLR) clr_cnt_r <= clr_cnt_r + AW'(1);
      else clr_cnt_r <= '0;
    end
  end

  // per-request datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      bfiq_pkg::ST_IDLE: begin
        req_r   <= in_tuser;
        key_r   <= in_tdata;
        probe_r <= '0;
        hit_r   <= 1'b1;
      end
      bfiq_pkg::ST_SEED: begin
        a_r       <= seed_mix + key_r;
        b_r       <= seed_mix;
        c_r       <= seed_mix;
        mix_cnt_r <= '0;
      end
      bfiq_pkg::ST_MIX: begin
        a_r       <= a_nxt;
        b_r       <= b_nxt;
        c_r       <= c_nxt;
        mix_cnt_r <= mix_cnt_r + MIXW'(1);
        div_r     <= c_nxt;
        rem_r     <= '0;
        mod_cnt_r <= '0;
      end
      bfiq_pkg::ST_MOD: begin
        rem_r     <= rem_nxt;
        div_r     <= div_r << RB;
        mod_cnt_r <= mod_cnt_r + MODW'(1);
      end
      bfiq_pkg::ST_UPD: begin
        probe_r <= probe_r + CW'(1);
        if (!probe_bit) hit_r <= 1'b0;
      end
      default: ;
    endcase
  end

  // result register: holds a query answer until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == bfiq_pkg::ST_FIN && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bfiq_pkg::ST_FIN && (!out_valid_r || out_tready)) out_bit_r <= hit_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

  `ASSERT_IMPL(a_clr_blocks_input, clk, rst_n, state_r == bfiq_pkg::ST_CLR, !in_tready,
               "input taken during clearing pass")
  `ASSERT_IMPL(a_write_in_range, clk, rst_n, mem_we, 32'(mem_wa) < 32'(STORE_WORDS),
               "store write beyond last word")
  `ASSERT_IMPL(a_rem_below_mod, clk, rst_n, state_r == bfiq_pkg::ST_RD,
               rem_r < {1'b0, modulus}, "bit index not reduced below modulus")
  `ASSERT_IMPL(a_probe_bounded, clk, rst_n, state_r == bfiq_pkg::ST_SEED,
               probe_r < probe_total, "probe count overran hash count")
  `ASSERT_NEXT(a_fin_gives_result, clk, rst_n,
               state_r == bfiq_pkg::ST_FIN && !out_valid_r, out_valid_r,
               "finished query produced no result")

endmodule

// ----- bench/bfiq_checker.sv -----
`timescale 1ns / 100ps

module bfiq_checker #(
  parameter int STORE_WORDS = 64,
  parameter int MAX_HASHES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam int STORE_BITS = STORE_WORDS * 64;

  logic [31:0] seed_q;
  logic [3:0]  count_q;
  logic [12:0] bits_q;
  logic [STORE_BITS-1:0] bloom_bits;
  logic [7:0] presence_q[$];

  assign pending = presence_q.size();

  function automatic logic [31:0] rol(input logic [31:0] x, input int k);
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [31:0] jmix(input logic [31:0] key, input logic [31:0] sd);
    logic [31:0] a, b, c;
    a = 32'hDEADBEEF + 32'd4 + sd;
    b = a;
    c = a;
    a += key;
    c ^= b; c -= rol(b, 14);
    a ^= c; a -= rol(c, 11);
    b ^= a; b -= rol(a, 25);
    c ^= b; c -= rol(b, 16);
    a ^= c; a -= rol(c, 4);
    b ^= a; b -= rol(a, 14);
    c ^= b; c -= rol(b, 24);
    return c;
  endfunction

  function automatic int bit_pos(input logic [31:0] key, input int i);
    int unsigned m;
    m = (bits_q == 0 || bits_q > STORE_BITS) ? STORE_BITS : bits_q;
    return jmix(key, seed_q + i) % m;
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int n;
    logic hit;
    if (!rst_n) begin
      seed_q = bfiq_pkg::SEED_RST;
      count_q = bfiq_pkg::COUNT_RST;
      bits_q = bfiq_pkg::BITS_RST;
      bloom_bits = '0;
      presence_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bfiq_pkg::CFG_SEED:  seed_q = cfg_data;
          bfiq_pkg::CFG_COUNT: count_q = cfg_data[3:0];
          bfiq_pkg::CFG_BITS:  bits_q = cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        n = (count_q == 0) ? 1 : (count_q > MAX_HASHES ? MAX_HASHES : count_q);
        case (in_tuser)
          bfiq_pkg::REQ_INSERT:
            for (int i = 0; i < n; i++) bloom_bits[bit_pos(in_tdata, i)] = 1'b1;
          bfiq_pkg::REQ_QUERY: begin
            hit = 1'b1;
            for (int i = 0; i < n; i++) hit &= bloom_bits[bit_pos(in_tdata, i)];
            presence_q.push_back({7'd0, hit});
          end
          bfiq_pkg::REQ_CLEAR: bloom_bits = '0;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (presence_q.size() == 0) report("unexpected result", out_tdata, 8'h00);
        else begin
          logic [7:0] want;
          want = presence_q.pop_front();
          if (out_tdata !== want) report("maybe_present", out_tdata, want);
        end
      end
    end
  end
endmodule

// ----- bench/tb_bloom_filter_insert_query.sv -----
`timescale 1ns / 100ps

module tb_bloom_filter_insert_query;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] key
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] maybe_present
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;

  // idle rates in percent, changed per phase
  int send_idle;
  int recv_idle;
  logic [31:0] key_pool[16];

  bloom_filter_insert_query u_dut (.*);

  bfiq_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stalls at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #50ms;
    $display("** bloom_filter_insert_query: FAILED **");
    $finish;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one transfer on the input side, with a random gap before it;
  // valid stays up until the next gap, the next item or the idle point
  task automatic send(input logic [1:0] req, input logic [31:0] key);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
  endtask

  // idle point: nothing outstanding and the last request finished
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    int r;
    logic [1:0] req;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      req = (r < 45) ? bfiq_pkg::REQ_INSERT : (r < 92) ? bfiq_pkg::REQ_QUERY :
            (r < 96) ? bfiq_pkg::REQ_CLEAR : bfiq_pkg::REQ_UNUSED;
      // reuse keys so many queries hit inserted elements
      send(req, ($urandom_range(1) != 0) ? key_pool[$urandom_range(15)] : $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 15;
    recv_idle = 56;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, key extremes, all request kinds
    send(bfiq_pkg::REQ_QUERY, 32'h0);
    send(bfiq_pkg::REQ_INSERT, 32'h0);
    send(bfiq_pkg::REQ_QUERY, 32'h0);
    send(bfiq_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send(bfiq_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    send(bfiq_pkg::REQ_QUERY, 32'h1234_5678);
    send(bfiq_pkg::REQ_UNUSED, 32'hFFFF_FFFF);
    send(bfiq_pkg::REQ_CLEAR, 32'hA5A5_A5A5);
    send(bfiq_pkg::REQ_QUERY, 32'hFFFF_FFFF);
    drain();
    // zero probe count and zero modulus
    cfg_write(bfiq_pkg::CFG_COUNT, 32'd0);
    cfg_write(bfiq_pkg::CFG_BITS, 32'd0);
    cfg_write(bfiq_pkg::CFG_SEED, 32'hFFFF_FFFF);
    send(bfiq_pkg::REQ_INSERT, 32'h5555_5555);
    send(bfiq_pkg::REQ_QUERY, 32'h5555_5555);
    send(bfiq_pkg::REQ_QUERY, 32'hAAAA_AAAA);
    drain();
    // large probe count, modulus over the store, bad register index
    cfg_write(bfiq_pkg::CFG_COUNT, 32'hFFFF_FFFF);
    cfg_write(bfiq_pkg::CFG_BITS, 32'h1FFF);
    cfg_write(bfiq_pkg::CFG_UNUSED, 32'hFFFF_FFFF);
    send(bfiq_pkg::REQ_INSERT, 32'h8000_0001);
    send(bfiq_pkg::REQ_QUERY, 32'h8000_0001);
    drain();
    // modulus of one: every index is zero
    cfg_write(bfiq_pkg::CFG_BITS, 32'd1);
    cfg_write(bfiq_pkg::CFG_COUNT, 32'd1);
    send(bfiq_pkg::REQ_QUERY, 32'h7);
    send(bfiq_pkg::REQ_INSERT, 32'h9);
    send(bfiq_pkg::REQ_QUERY, 32'h7);
    drain();

    // random phases across settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 56; recv_idle = 15; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      cfg_write(bfiq_pkg::CFG_SEED, (ph == 5) ? 32'hFFFF_FFFF : $urandom);
      cfg_write(bfiq_pkg::CFG_COUNT, (ph == 0) ? 8 : (ph == 3) ? 1 : $urandom_range(1, 8));
      cfg_write(bfiq_pkg::CFG_BITS,
                (ph == 1) ? 4096 : (ph == 2) ? 64 : $urandom_range(1, 4096));
      send(bfiq_pkg::REQ_CLEAR, $urandom);
      random_items(145);
      drain();
    end

    if (fail_count == 0) begin
      $display("** bloom_filter_insert_query: PASSED **");
    end else begin
      $display("** bloom_filter_insert_query: FAILED **");
    end
    $finish;
  end
endmodule

// ----- bloom_filter_insert_query.f -----
+incdir+hdl
hdl/bfiq_pkg.sv
hdl/bloom_filter_insert_query.sv
bench/bfiq_checker.sv
bench/tb_bloom_filter_insert_query.sv
